// ===== src/rgb_to_hsl_converter_defines.svh =====
// Assertion macros used by the checker file.
`ifndef RGB_TO_HSL_CONVERTER_DEFINES_SVH
`define RGB_TO_HSL_CONVERTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RHC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rhc checker: implication failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RHC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rhc checker: next-cycle implication failed");

`endif

// ===== src/rhc_pkg.sv =====
// Types, constants and the divider step shared by the converter modules.
package rhc_pkg;

  localparam int CB = 16;        // channel width
  localparam int NW = CB + 3;    // width of six times delta
  localparam logic [CB-1:0] FULL = {CB{1'b1}};

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // One beat inside the divider pipeline.
  typedef struct packed {
    logic [NW-1:0] h_rem;
    logic [NW-1:0] h_den;
    logic [CB-1:0] h_quo;
    logic [CB-1:0] s_rem;
    logic [CB-1:0] s_den;
    logic [CB-1:0] s_low;
    logic [CB-1:0] s_quo;
    logic          undef;
    logic [CB-1:0] light;
    logic [CB-1:0] alpha;
  } div_t;

  // Produce one quotient bit of each of the two restoring divisions.
  function automatic div_t div_step(div_t d);
    div_t        n;
    logic [NW:0] ht;
    logic [CB:0] st;
    n  = d;
    ht = {d.h_rem, 1'b0};
    st = {d.s_rem, d.s_low[CB-1]};
    n.s_low = {d.s_low[CB-2:0], 1'b0};
    if (ht >= {1'b0, d.h_den}) begin
      ht = ht - {1'b0, d.h_den};
      n.h_quo = {d.h_quo[CB-2:0], 1'b1};
    end else begin
      n.h_quo = {d.h_quo[CB-2:0], 1'b0};
    end
    if (st >= {1'b0, d.s_den}) begin
      st = st - {1'b0, d.s_den};
      n.s_quo = {d.s_quo[CB-2:0], 1'b1};
    end else begin
      n.s_quo = {d.s_quo[CB-2:0], 1'b0};
    end
    n.h_rem = ht[NW-1:0];
    n.s_rem = st[CB-1:0];
    return n;
  endfunction

endpackage

// ===== src/rhc_div_step.sv =====
// One registered stage of the hue and saturation dividers.
module rhc_div_step (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         valid_i,
  output logic         ready_o,
  input  rhc_pkg::div_t data_i,
  output logic         valid_o,
  input  logic         ready_i,
  output rhc_pkg::div_t data_o
);
  import rhc_pkg::*;

  logic v_r;
  div_t d_r;

  assign ready_o = !v_r || ready_i;
  assign valid_o = v_r;
  assign data_o  = d_r;

  // Advance valid when the stage is free or drains.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_o) begin
      v_r <= valid_i;
    end
  end

  // Load the next quotient bit.
  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      d_r <= div_step(data_i);
    end
  end
endmodule

// ===== src/rgb_to_hsl_converter.sv =====
// Top level of the RGB plus alpha to HSL plus alpha converter.
// Usage:
//   Input channel in_valid/in_ready carries one pixel (in_red, in_green,
//   in_blue, in_alpha_in) per beat; channels are unsigned fractions, all ones
//   meaning 1.0. Output channel out_valid/out_ready carries hue, the
//   hue_undefined flag, saturation, lightness and the alpha copy per beat.
//   Throughput: one pixel per clock while out_ready stays high. Pipeline:
//   one stage for max/min and sector, one for delta, sum and divider setup,
//   and sixteen stages that each produce one quotient bit of the hue and
//   saturation divisions.
//   Grey pixels give hue 0, saturation 0 and hue_undefined set.
//   Reset (rst_n low, synchronous) empties every stage.
//   When the receiver stalls, each stage holds its beat while earlier
//   stages keep filling empty slots; in_ready drops only when the whole
//   pipeline is full.
module rgb_to_hsl_converter (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [rhc_pkg::CB-1:0] in_red,
  input  logic [rhc_pkg::CB-1:0] in_green,
  input  logic [rhc_pkg::CB-1:0] in_blue,
  input  logic [rhc_pkg::CB-1:0] in_alpha_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [rhc_pkg::CB-1:0] out_hue,
  output logic                   out_hue_undefined,
  output logic [rhc_pkg::CB-1:0] out_saturation,
  output logic [rhc_pkg::CB-1:0] out_lightness,
  output logic [rhc_pkg::CB-1:0] out_alpha_out
);
  import rhc_pkg::*;

  // Stage 1: max, min, sector and signed difference.
  logic           s1_v_r;
  logic [CB-1:0]  s1_mx_r, s1_mx_nxt;
  logic [CB-1:0]  s1_mn_r, s1_mn_nxt;
  sector_t        s1_sec_r, s1_sec_nxt;
  logic [CB:0]    s1_diff_r, s1_diff_nxt;
  logic [CB-1:0]  s1_alpha_r;
  logic           s1_ready;

  // Stage 2: divider setup.
  logic           s2_v_r;
  div_t           s2_d_r, s2_d_nxt;
  logic           s2_ready;

  // Divider chain links.
  logic           dv_v  [CB+1];
  logic           dv_rd [CB+1];
  div_t           dv_d  [CB+1];

  assign in_ready = s1_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign s2_ready = !s2_v_r || dv_rd[0];

  // Find max and min, red first, then green.
  always_comb begin
    s1_mx_nxt = in_red;
    s1_mn_nxt = in_red;
    if (in_green > s1_mx_nxt) s1_mx_nxt = in_green;
    if (in_blue > s1_mx_nxt)  s1_mx_nxt = in_blue;
    if (in_green < s1_mn_nxt) s1_mn_nxt = in_green;
    if (in_blue < s1_mn_nxt)  s1_mn_nxt = in_blue;
    priority if (in_red == s1_mx_nxt) begin
      s1_sec_nxt  = SEC_RED;
      s1_diff_nxt = {1'b0, in_green} - {1'b0, in_blue};
    end else if (in_green == s1_mx_nxt) begin
      s1_sec_nxt  = SEC_GREEN;
      s1_diff_nxt = {1'b0, in_blue} - {1'b0, in_red};
    end else begin
      s1_sec_nxt  = SEC_BLUE;
      s1_diff_nxt = {1'b0, in_red} - {1'b0, in_green};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_mx_r    <= s1_mx_nxt;
      s1_mn_r    <= s1_mn_nxt;
      s1_sec_r   <= s1_sec_nxt;
      s1_diff_r  <= s1_diff_nxt;
      s1_alpha_r <= in_alpha_in;
    end
  end

  // Build delta, sum, denominators and the wrapped hue numerator.
  always_comb begin
    logic [CB-1:0]   delta;
    logic [CB:0]     sum;
    logic [CB:0]     two_full;
    logic [NW-1:0]   six;
    logic [NW:0]     base;
    logic [NW:0]     num;
    logic [2*CB-1:0] sat_num;
    delta    = s1_mx_r - s1_mn_r;
    sum      = {1'b0, s1_mx_r} + {1'b0, s1_mn_r};
    two_full = {FULL, 1'b0};
    six      = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};
    unique case (s1_sec_r)
      SEC_GREEN: base = {2'b00, delta, 2'b00} >> 1;
      SEC_BLUE:  base = {2'b00, delta, 2'b00};
      default:   base = '0;
    endcase
    num = base + {{(NW-CB){s1_diff_r[CB]}}, s1_diff_r};
    if (num[NW]) num = num + {1'b0, six};
    if (num >= {1'b0, six}) num = num - {1'b0, six};
    sat_num = {delta, {CB{1'b0}}} - {{CB{1'b0}}, delta};

    s2_d_nxt       = '0;
    s2_d_nxt.h_rem = num[NW-1:0];
    s2_d_nxt.h_den = six;
    s2_d_nxt.s_rem = sat_num[2*CB-1:CB];
    s2_d_nxt.s_low = sat_num[CB-1:0];
    if (sum <= {1'b0, FULL}) begin
      s2_d_nxt.s_den = sum[CB-1:0];
    end else begin
      s2_d_nxt.s_den = CB'(two_full - sum);
    end
    s2_d_nxt.undef = (delta == '0);
    s2_d_nxt.light = sum[CB:1];
    s2_d_nxt.alpha = s1_alpha_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_ready) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && s2_ready) begin
      s2_d_r <= s2_d_nxt;
    end
  end

  // Divider chain: one quotient bit per stage.
  assign dv_v[0] = s2_v_r;
  assign dv_d[0] = s2_d_r;
  assign dv_rd[CB] = out_ready;

  for (genvar i = 0; i < CB; i++) begin : g_div
    rhc_div_step u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (dv_v[i]),
      .ready_o (dv_rd[i]),
      .data_i  (dv_d[i]),
      .valid_o (dv_v[i+1]),
      .ready_i (dv_rd[i+1]),
      .data_o  (dv_d[i+1])
    );
  end

  // Drive results; grey pixels force hue and saturation to zero.
  assign out_valid         = dv_v[CB];
  assign out_hue_undefined = dv_d[CB].undef;
  assign out_hue           = dv_d[CB].undef ? '0 : dv_d[CB].h_quo;
  assign out_saturation    = dv_d[CB].undef ? '0 : dv_d[CB].s_quo;
  assign out_lightness     = dv_d[CB].light;
  assign out_alpha_out     = dv_d[CB].alpha;
endmodule

// ===== src/rhc_checker.sv =====
// Port-level checker for the converter and its bind.
`include "rgb_to_hsl_converter_defines.svh"

module rhc_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [rhc_pkg::CB-1:0] out_hue,
  input logic                   out_hue_undefined,
  input logic [rhc_pkg::CB-1:0] out_saturation,
  input logic [rhc_pkg::CB-1:0] out_lightness,
  input logic [rhc_pkg::CB-1:0] out_alpha_out
);
  // Grey pixels carry zero hue and zero saturation.
  `RHC_ASSERT_IMPL(a_grey_zero, out_valid && out_hue_undefined, out_hue == '0 && out_saturation == '0)
  // A colored pixel always has some saturation.
  `RHC_ASSERT_IMPL(a_color_sat, out_valid && !out_hue_undefined, out_saturation != '0)
  // A stalled result beat holds.
  `RHC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_hue) && $stable(out_saturation) && $stable(out_lightness) && $stable(out_alpha_out))
  // An empty output stage leaves room at the input unless a beat just entered.
  `RHC_ASSERT_NEXT(a_empty_ready, !out_valid, in_ready || $past(in_valid))
endmodule

bind rgb_to_hsl_converter rhc_checker u_rhc_checker (.*);
